// File: rtl/psadpcm_pkg.sv
package psadpcm_pkg;

    localparam int MAX_CHANNELS     = 8;
    localparam int DATA_BYTES       = 14;
    localparam int SHORT_DATA_BYTES = 14;

    localparam int BYTE_W   = 8;
    localparam int POS_W    = 4;
    localparam int SHIFT_W  = 4;
    localparam int PRED_W   = 3;
    localparam int CHAN_W   = 3;
    localparam int CNT_W    = 4;
    localparam int HIST_W   = 24;
    localparam int COEF_W   = 8;
    localparam int PROD_W   = HIST_W + COEF_W;
    localparam int ACC_W    = 34;
    localparam int BASE_W   = 16;
    localparam int PCM_W    = 16;
    localparam int CFG_IDX_W = 3;
    localparam int S_USER_W = 1;
    localparam int M_USER_W = CHAN_W + 2;

    localparam logic [POS_W-1:0] HEADER_POS     = POS_W'(0);
    localparam logic [POS_W-1:0] FLAG_POS       = POS_W'(1);
    localparam logic [POS_W-1:0] STD_DATA_POS   = POS_W'(2);
    localparam logic [POS_W-1:0] STD_LAST_POS   = POS_W'(1 + DATA_BYTES);
    localparam logic [POS_W-1:0] SHORT_LAST_POS = POS_W'(SHORT_DATA_BYTES);

    localparam logic [3:0] PRED_MAX = 4'd4;

    localparam logic [CFG_IDX_W-1:0] CFG_BLOCK_FORMAT    = CFG_IDX_W'(0);
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNEL_COUNT   = CFG_IDX_W'(1);
    localparam logic [CFG_IDX_W-1:0] CFG_END_FLAG_CODE   = CFG_IDX_W'(2);
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_START_CODE = CFG_IDX_W'(3);
    localparam logic [CFG_IDX_W-1:0] CFG_LOOP_END_CODE   = CFG_IDX_W'(4);

    localparam logic [1:0] MARK_NONE       = 2'b00;
    localparam logic [1:0] MARK_LOOP_START = 2'b01;
    localparam logic [1:0] MARK_LOOP_END   = 2'b10;

    typedef logic signed [HIST_W-1:0] t_hist;
    typedef logic signed [COEF_W-1:0] t_coef;

    typedef enum logic [1:0] {
        BYTE_DROP,
        BYTE_HEADER,
        BYTE_FLAG,
        BYTE_DATA
    } t_byte_kind;

    // Weight of the newer history sample, in 1/64 units.
    function automatic t_coef coef_newer(input logic [PRED_W-1:0] pred);
        t_coef c;
        unique case (pred)
            3'd1:    c = 8'sd60;
            3'd2:    c = 8'sd115;
            3'd3:    c = 8'sd98;
            3'd4:    c = 8'sd122;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

    // Weight of the older history sample, in 1/64 units.
    function automatic t_coef coef_older(input logic [PRED_W-1:0] pred);
        t_coef c;
        unique case (pred)
            3'd2:    c = -8'sd52;
            3'd3:    c = -8'sd55;
            3'd4:    c = -8'sd60;
            default: c = 8'sd0;
        endcase
        return c;
    endfunction

endpackage

// File: rtl/ps_adpcm_block_decoder.sv
// Block ADPCM stream decoder. Compressed bytes enter on the slave stream, one
// byte per request, with tuser[0] marking the first byte of a new stream.
// Header and flag bytes give no sample; a data byte gives two samples, low
// nibble first; each nibble passes through the one predictor multiply-add and
// the history update in its own cycle, and the output register carries one
// sample per cycle while the receiver does not stall. A data byte
// waits in the input register while the output register holds an untaken
// sample. Samples leave on the master stream with the pcm value in tdata,
// the channel and the loop-block marks in tuser, and tlast on the second
// sample of each byte. Configuration writes are taken at any time but are
// meant for when the decoder is idle.
module ps_adpcm_block_decoder (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  logic [psadpcm_pkg::CFG_IDX_W-1:0]    i_cfg_index,
    input  logic [psadpcm_pkg::BYTE_W-1:0]       i_cfg_data,
    input  logic                                 s_axis_tvalid,
    output logic                                 s_axis_tready,
    input  logic [psadpcm_pkg::BYTE_W-1:0]       s_axis_tdata,   // [7:0] stream_byte
    input  logic [psadpcm_pkg::S_USER_W-1:0]     s_axis_tuser,   // [0] stream_start
    output logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    output logic [psadpcm_pkg::PCM_W-1:0]        m_axis_tdata,   // [15:0] pcm_sample
    output logic [psadpcm_pkg::M_USER_W-1:0]     m_axis_tuser,   // [2:0] channel_index,
                                                                 // [3] in_loop_start_block,
                                                                 // [4] in_loop_end_block
    output logic                                 m_axis_tlast    // last_of_pair
);
    import psadpcm_pkg::*;

    // configuration
    logic                r_fmt;
    logic [CNT_W-1:0]    r_chan_cnt;
    logic [BYTE_W-1:0]   r_end_code;
    logic [BYTE_W-1:0]   r_ls_code;
    logic [BYTE_W-1:0]   r_le_code;

    // input register
    logic                r_in_valid;
    logic [BYTE_W-1:0]   r_in_byte;
    logic                r_in_start;

    // block state
    logic [POS_W-1:0]    r_pos,   n_pos;
    logic [SHIFT_W-1:0]  r_shift, n_shift;
    logic [PRED_W-1:0]   r_pred,  n_pred;
    logic [1:0]          r_marks, n_marks;
    logic                r_ended, n_ended;
    logic [CHAN_W-1:0]   r_chan,  n_chan;
    logic                r_phase, n_phase;

    t_hist               r_hist_new [MAX_CHANNELS];
    t_hist               r_hist_old [MAX_CHANNELS];

    // output register
    logic                r_out_valid;
    logic [PCM_W-1:0]    r_out_pcm;
    logic [CHAN_W-1:0]   r_out_chan;
    logic [1:0]          r_out_marks;
    logic                r_out_last;

    t_byte_kind          w_kind;
    logic                w_out_free;
    logic                w_step;
    logic                w_done;
    logic                w_data_step;
    logic [POS_W-1:0]    w_pos;
    logic [CHAN_W-1:0]   w_slot;
    logic [3:0]          w_nib;
    logic signed [BASE_W-1:0] w_base;
    logic signed [PROD_W-1:0] w_prod_new;
    logic signed [PROD_W-1:0] w_prod_old;
    logic signed [ACC_W-1:0]  w_acc;
    logic signed [ACC_W-1:0]  w_acc_rnd;
    logic signed [ACC_W-7:0]  w_hq;
    t_hist               w_hist;
    logic signed [HIST_W:0]   w_h_rnd;
    logic signed [HIST_W-6:0] w_pq;
    logic [PCM_W-1:0]    w_pcm;
    logic [1:0]          w_out_marks;
    logic [POS_W-1:0]    w_last_pos;
    logic [CNT_W-1:0]    w_cnt;
    logic [CNT_W-1:0]    w_chan_inc;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fmt      <= 1'b0;
            r_chan_cnt <= CNT_W'(1);
            r_end_code <= BYTE_W'(7);
            r_ls_code  <= BYTE_W'(6);
            r_le_code  <= BYTE_W'(3);
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                CFG_BLOCK_FORMAT:    r_fmt      <= i_cfg_data[0];
                CFG_CHANNEL_COUNT:   r_chan_cnt <= i_cfg_data[CNT_W-1:0];
                CFG_END_FLAG_CODE:   r_end_code <= i_cfg_data;
                CFG_LOOP_START_CODE: r_ls_code  <= i_cfg_data;
                CFG_LOOP_END_CODE:   r_le_code  <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // A stream start clears the state before the byte is looked at, and the
    // byte itself is then always a header.
    always_comb begin
        w_pos = r_in_start ? HEADER_POS : r_pos;
        priority if (r_ended && !r_in_start) begin
            w_kind = BYTE_DROP;
        end else if (w_pos == HEADER_POS) begin
            w_kind = BYTE_HEADER;
        end else if (!r_fmt && w_pos == FLAG_POS) begin
            w_kind = BYTE_FLAG;
        end else begin
            w_kind = BYTE_DATA;
        end
    end

    assign w_out_free    = !r_out_valid || m_axis_tready;
    assign w_step        = r_in_valid && (w_kind != BYTE_DATA || w_out_free);
    assign w_data_step   = w_step && w_kind == BYTE_DATA;
    assign w_done        = w_step && (w_kind != BYTE_DATA || r_phase);
    assign s_axis_tready = !r_in_valid || w_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tready && s_axis_tvalid) begin
            r_in_byte  <= s_axis_tdata;
            r_in_start <= s_axis_tuser[0];
        end
    end

    // sample arithmetic for the nibble of the current phase
    always_comb begin
        w_slot     = r_fmt ? r_chan : '0;
        w_nib      = r_phase ? r_in_byte[7:4] : r_in_byte[3:0];
        w_base     = $signed({w_nib, 12'd0}) >>> r_shift;
        w_prod_new = r_hist_new[w_slot] * coef_newer(r_pred);
        w_prod_old = r_hist_old[w_slot] * coef_older(r_pred);
        w_acc      = ACC_W'(w_base) * ACC_W'(4096) + ACC_W'(w_prod_new)
                   + ACC_W'(w_prod_old);

        // Adding 31 instead of 32 to a negative value rounds the halves away
        // from zero under the floor of the arithmetic shift.
        w_acc_rnd = w_acc + (w_acc[ACC_W-1] ? ACC_W'(31) : ACC_W'(32));
        w_hq      = w_acc_rnd[ACC_W-1:6];
        if (w_hq[ACC_W-7:HIST_W-1] == '0 || w_hq[ACC_W-7:HIST_W-1] == '1) begin
            w_hist = w_hq[HIST_W-1:0];
        end else begin
            w_hist = w_hq[ACC_W-7] ? {1'b1, {(HIST_W-1){1'b0}}}
                                   : {1'b0, {(HIST_W-1){1'b1}}};
        end

        w_h_rnd = {w_hist[HIST_W-1], w_hist}
                + (w_hist[HIST_W-1] ? (HIST_W+1)'(31) : (HIST_W+1)'(32));
        w_pq    = w_h_rnd[HIST_W:6];
        if (w_pq[HIST_W-6:PCM_W-1] == '0 || w_pq[HIST_W-6:PCM_W-1] == '1) begin
            w_pcm = w_pq[PCM_W-1:0];
        end else begin
            w_pcm = w_pq[HIST_W-6] ? {1'b1, {(PCM_W-1){1'b0}}}
                                   : {1'b0, {(PCM_W-1){1'b1}}};
        end

        w_out_marks = r_fmt ? MARK_NONE : r_marks;
    end

    // end of block and channel rotation
    always_comb begin
        w_last_pos = r_fmt ? SHORT_LAST_POS : STD_LAST_POS;
        if (r_chan_cnt == '0) begin
            w_cnt = CNT_W'(1);
        end else if (r_chan_cnt > CNT_W'(MAX_CHANNELS)) begin
            w_cnt = CNT_W'(MAX_CHANNELS);
        end else begin
            w_cnt = r_chan_cnt;
        end
        w_chan_inc = {1'b0, r_chan} + CNT_W'(1);
    end

    always_comb begin
        n_pos   = r_pos;
        n_shift = r_shift;
        n_pred  = r_pred;
        n_marks = r_marks;
        n_ended = r_ended;
        n_chan  = r_chan;
        n_phase = r_phase;
        if (w_step) begin
            if (r_in_start) begin
                n_pos   = HEADER_POS;
                n_shift = '0;
                n_pred  = '0;
                n_marks = MARK_NONE;
                n_ended = 1'b0;
                n_chan  = '0;
            end
            unique case (w_kind)
                BYTE_DROP: ;
                BYTE_HEADER: begin
                    n_shift = r_in_byte[3:0];
                    n_pred  = (r_in_byte[7:4] > PRED_MAX) ? '0 : r_in_byte[6:4];
                    if (r_fmt) begin
                        n_marks = MARK_NONE;
                    end
                    n_pos = FLAG_POS;
                end
                BYTE_FLAG: begin
                    if (r_in_byte == r_end_code) begin
                        n_ended = 1'b1;
                        n_pos   = HEADER_POS;
                    end else begin
                        priority if (r_in_byte == r_ls_code) begin
                            n_marks = MARK_LOOP_START;
                        end else if (r_in_byte == r_le_code) begin
                            n_marks = MARK_LOOP_END;
                        end else begin
                            n_marks = MARK_NONE;
                        end
                        n_pos = STD_DATA_POS;
                    end
                end
                BYTE_DATA: begin
                    n_phase = !r_phase;
                    if (r_phase) begin
                        if (r_pos >= w_last_pos) begin
                            n_pos = HEADER_POS;
                            if (r_fmt) begin
                                n_chan = (w_chan_inc >= w_cnt) ? '0
                                                               : w_chan_inc[CHAN_W-1:0];
                            end
                        end else begin
                            n_pos = r_pos + POS_W'(1);
                        end
                    end
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos   <= HEADER_POS;
            r_shift <= '0;
            r_pred  <= '0;
            r_marks <= MARK_NONE;
            r_ended <= 1'b0;
            r_chan  <= '0;
            r_phase <= 1'b0;
        end else begin
            r_pos   <= n_pos;
            r_shift <= n_shift;
            r_pred  <= n_pred;
            r_marks <= n_marks;
            r_ended <= n_ended;
            r_chan  <= n_chan;
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n || (w_step && r_in_start)) begin
            for (int c = 0; c < MAX_CHANNELS; c++) begin
                r_hist_new[c] <= '0;
                r_hist_old[c] <= '0;
            end
        end else if (w_data_step) begin
            r_hist_old[w_slot] <= r_hist_new[w_slot];
            r_hist_new[w_slot] <= w_hist;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_data_step) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_data_step) begin
            r_out_pcm   <= w_pcm;
            r_out_chan  <= w_slot;
            r_out_marks <= w_out_marks;
            r_out_last  <= r_phase;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_pcm;
    assign m_axis_tuser  = {r_out_marks, r_out_chan};
    assign m_axis_tlast  = r_out_last;

endmodule

// File: rtl/psadpcm_checker.sv
module psadpcm_checker (
    input  logic                                 i_clk,
    input  logic                                 i_rst_n,
    input  logic                                 m_axis_tvalid,
    input  logic                                 m_axis_tready,
    input  logic [psadpcm_pkg::PCM_W-1:0]        m_axis_tdata,
    input  logic [psadpcm_pkg::M_USER_W-1:0]     m_axis_tuser,
    input  logic                                 m_axis_tlast
);
    import psadpcm_pkg::*;

    // Samples come in pairs from one byte, so the pair position of the
    // next sample follows from how many samples were taken so far.
    logic r_expect_hi;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_expect_hi <= 1'b0;
        end else if (m_axis_tvalid && m_axis_tready) begin
            r_expect_hi <= !r_expect_hi;
        end
    end

    a_out_idle_after_reset: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("sample offered right after reset");

    a_pair_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tlast == r_expect_hi)
        else $error("samples of a byte not delivered as a low/high pair");

    a_marks_exclusive: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> !(m_axis_tuser[CHAN_W] && m_axis_tuser[CHAN_W+1]))
        else $error("sample marked as both loop start and loop end block");

    a_stall_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata)
            && $stable(m_axis_tuser) && $stable(m_axis_tlast))
        else $error("stalled sample changed");

endmodule

bind ps_adpcm_block_decoder psadpcm_checker u_psadpcm_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
);

// File: bench/ps_adpcm_block_decoder_tb.sv
module ps_adpcm_block_decoder_tb;
    import psadpcm_pkg::*;

    localparam int IDLE_PCT       = 20;
    localparam int SETTLE_CYCLES  = 8;
    localparam int DRAIN_CYCLES   = 20;
    localparam int SINK_HOLD      = 300;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int PHASE_BYTES    = 150;

    localparam logic [7:0] END_CODE_RESET        = 8'h07;
    localparam logic [7:0] LOOP_START_CODE_RESET = 8'h06;
    localparam logic [7:0] LOOP_END_CODE_RESET   = 8'h03;

    localparam longint HIST_MAX = 64'sd8388607;
    localparam longint HIST_MIN = -64'sd8388608;

    typedef struct packed {
        logic [7:0] data;
        logic       start;
    } t_stream_item;

    typedef struct packed {
        logic signed [15:0] pcm;
        logic [2:0]         chan;
        logic               loop_start;
        logic               loop_end;
        logic               second;
    } t_sample;

    logic                 i_clk = 1'b0;
    logic                 i_rst_n = 1'b0;
    logic                 i_cfg_valid = 1'b0;
    logic                 o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index = '0;
    logic [BYTE_W-1:0]    i_cfg_data = '0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    logic [BYTE_W-1:0]    s_axis_tdata = '0;
    logic [S_USER_W-1:0]  s_axis_tuser = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    logic [PCM_W-1:0]     m_axis_tdata;
    logic [M_USER_W-1:0]  m_axis_tuser;
    logic                 m_axis_tlast;

    // Shadow of the decoder configuration and stream state.
    logic       cfg_format;
    logic [3:0] cfg_channels;
    logic [7:0] cfg_end_code;
    logic [7:0] cfg_loop_start_code;
    logic [7:0] cfg_loop_end_code;

    logic [3:0] pos;
    logic [3:0] blk_shift;
    logic [2:0] blk_pred;
    logic [1:0] blk_marks;
    logic       ended;
    logic [2:0] chan;
    t_hist      hist_new [MAX_CHANNELS];
    t_hist      hist_old [MAX_CHANNELS];

    t_stream_item stream_bytes [$];
    t_sample      pending_samples [$];
    t_stream_item drive_item;

    int  bytes_queued = 0;
    int  bytes_taken = 0;
    int  samples_seen = 0;
    int  error_count = 0;
    int  quiet_cycles = 0;
    int  sink_hold_left = 0;
    bit  no_idle = 1'b0;
    bit  byte_accepted = 1'b0;

    ps_adpcm_block_decoder DUT (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_valid   (i_cfg_valid),
        .o_cfg_ready   (o_cfg_ready),
        .i_cfg_index   (i_cfg_index),
        .i_cfg_data    (i_cfg_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    always #5 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        $display("ERROR at %0t: %s", $time, msg);
        error_count++;
    endtask

    task automatic compare_field(input string name, input int got, input int want);
        if (got != want) begin
            report_mismatch($sformatf("sample %0d %s: got %0d, expected %0d",
                                      samples_seen, name, got, want));
        end
    endtask

    task automatic clear_stream();
        pos       = HEADER_POS;
        blk_shift = '0;
        blk_pred  = '0;
        blk_marks = MARK_NONE;
        ended     = 1'b0;
        chan      = '0;
        for (int c = 0; c < MAX_CHANNELS; c++) begin
            hist_new[c] = '0;
            hist_old[c] = '0;
        end
    endtask

    task automatic reset_model();
        cfg_format          = 1'b0;
        cfg_channels        = 4'd1;
        cfg_end_code        = END_CODE_RESET;
        cfg_loop_start_code = LOOP_START_CODE_RESET;
        cfg_loop_end_code   = LOOP_END_CODE_RESET;
        clear_stream();
    endtask

    task automatic write_model_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        case (idx)
            CFG_BLOCK_FORMAT:    cfg_format = data[0];
            CFG_CHANNEL_COUNT:   cfg_channels = data[3:0];
            CFG_END_FLAG_CODE:   cfg_end_code = data;
            CFG_LOOP_START_CODE: cfg_loop_start_code = data;
            CFG_LOOP_END_CODE:   cfg_loop_end_code = data;
            default: ;
        endcase
    endtask

    // Divide by 64 with halves rounded away from zero.
    function automatic longint round_div64(input longint v);
        if (v < 0) return -((-v + 32) / 64);
        return (v + 32) / 64;
    endfunction

    function automatic logic signed [15:0] decode_nibble(input int slot, input logic [3:0] nib);
        logic signed [15:0] scaled;
        longint base, acc, h, o;
        int c0, c1;
        case (blk_pred)
            3'd1: begin c0 = 60;  c1 = 0;   end
            3'd2: begin c0 = 115; c1 = -52; end
            3'd3: begin c0 = 98;  c1 = -55; end
            3'd4: begin c0 = 122; c1 = -60; end
            default: begin c0 = 0; c1 = 0; end
        endcase
        scaled = {nib, 12'd0};
        base = longint'(scaled >>> blk_shift);
        acc = base * 4096 + longint'(hist_new[slot]) * c0 + longint'(hist_old[slot]) * c1;
        h = round_div64(acc);
        if (h > HIST_MAX) h = HIST_MAX;
        if (h < HIST_MIN) h = HIST_MIN;
        hist_old[slot] = hist_new[slot];
        hist_new[slot] = h[23:0];
        o = round_div64(h);
        if (o > 32767) o = 32767;
        if (o < -32768) o = -32768;
        return o[15:0];
    endfunction

    // Advances the shadow state by one stream byte and queues the samples it yields.
    task automatic decode_byte(input logic [7:0] b, input logic start);
        logic       fmt;
        logic [1:0] mk;
        int         slot, cnt, nx;
        t_sample    s;
        fmt = cfg_format;
        if (start) clear_stream();
        if (ended) return;
        if (pos == HEADER_POS) begin
            blk_shift = b[3:0];
            blk_pred  = (b[7:4] > PRED_MAX) ? 3'd0 : b[6:4];
            if (fmt) blk_marks = MARK_NONE;
            pos = FLAG_POS;
            return;
        end
        if (!fmt && pos == FLAG_POS) begin
            if (b == cfg_end_code) begin
                ended = 1'b1;
                pos = HEADER_POS;
                return;
            end
            if (b == cfg_loop_start_code) blk_marks = MARK_LOOP_START;
            else if (b == cfg_loop_end_code) blk_marks = MARK_LOOP_END;
            else blk_marks = MARK_NONE;
            pos = STD_DATA_POS;
            return;
        end
        slot = fmt ? int'(chan) : 0;
        mk = fmt ? MARK_NONE : blk_marks;
        for (int k = 0; k < 2; k++) begin
            s.pcm        = decode_nibble(slot, (k == 1) ? b[7:4] : b[3:0]);
            s.chan       = slot[2:0];
            s.loop_start = mk[0];
            s.loop_end   = mk[1];
            s.second     = (k == 1);
            pending_samples = {pending_samples, s};
        end
        if (pos >= (fmt ? SHORT_LAST_POS : STD_LAST_POS)) begin
            pos = HEADER_POS;
            if (fmt) begin
                cnt = cfg_channels;
                if (cnt == 0) cnt = 1;
                if (cnt > MAX_CHANNELS) cnt = MAX_CHANNELS;
                nx = chan + 1;
                if (nx >= cnt) nx = 0;
                chan = nx[2:0];
            end
        end else begin
            pos = pos + 4'd1;
        end
    endtask

    task automatic check_sample();
        t_sample want;
        samples_seen++;
        if (pending_samples.size() == 0) begin
            report_mismatch($sformatf("sample %0d arrived with nothing pending (pcm %0d)",
                                      samples_seen, $signed(m_axis_tdata)));
            return;
        end
        want = pending_samples.pop_front();
        compare_field("pcm", $signed(m_axis_tdata), $signed(want.pcm));
        compare_field("channel", m_axis_tuser[2:0], want.chan);
        compare_field("loop start", m_axis_tuser[3], want.loop_start);
        compare_field("loop end", m_axis_tuser[4], want.loop_end);
        compare_field("last of pair", m_axis_tlast, want.second);
    endtask

    // Monitor, shadow model and watchdog.
    always @(posedge i_clk) begin
        byte_accepted <= i_rst_n && s_axis_tvalid && s_axis_tready;
        if (i_rst_n) begin
            if (i_cfg_valid && o_cfg_ready) write_model_reg(i_cfg_index, i_cfg_data);
            if (s_axis_tvalid && s_axis_tready) begin
                decode_byte(s_axis_tdata, s_axis_tuser[0]);
                bytes_taken++;
            end
            if (m_axis_tvalid && m_axis_tready) check_sample();
            if ((i_cfg_valid && o_cfg_ready) || (s_axis_tvalid && s_axis_tready)
                    || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("ERROR at %0t: no request accepted for %0d cycles", $time, quiet_cycles);
                $display("Test completed with failures");
                $finish;
            end
        end
    end

    // Byte sender: a new request is offered once the previous one was taken.
    always @(negedge i_clk) begin
        if (i_rst_n && (!s_axis_tvalid || byte_accepted)) begin
            if (stream_bytes.size() != 0 && (no_idle || $urandom_range(0, 99) >= IDLE_PCT)) begin
                drive_item = stream_bytes.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= drive_item.data;
                s_axis_tuser  <= drive_item.start;
            end else begin
                s_axis_tvalid <= 1'b0;
            end
        end
    end

    // Sample receiver with random back-pressure and one long hold-off.
    always @(negedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else if (sink_hold_left > 0) begin
            m_axis_tready  <= 1'b0;
            sink_hold_left <= sink_hold_left - 1;
        end else begin
            m_axis_tready <= no_idle || ($urandom_range(0, 99) >= IDLE_PCT);
        end
    end

    task automatic push_byte(input logic [7:0] data, input logic start);
        t_stream_item item;
        item.data  = data;
        item.start = start;
        stream_bytes = {stream_bytes, item};
        bytes_queued++;
    endtask

    task automatic wait_drained();
        while (bytes_taken != bytes_queued || pending_samples.size() != 0) @(negedge i_clk);
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [7:0] data);
        @(negedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic set_config(input logic fmt, input logic [3:0] cnt, input logic [7:0] end_code,
                              input logic [7:0] ls_code, input logic [7:0] le_code);
        wait_drained();
        // Header and flag bytes give no sample, so let the last of them finish.
        repeat (SETTLE_CYCLES) @(negedge i_clk);
        write_reg(CFG_BLOCK_FORMAT, {7'd0, fmt});
        write_reg(CFG_CHANNEL_COUNT, {4'd0, cnt});
        write_reg(CFG_END_FLAG_CODE, end_code);
        write_reg(CFG_LOOP_START_CODE, ls_code);
        write_reg(CFG_LOOP_END_CODE, le_code);
        @(negedge i_clk);
        i_cfg_valid <= 1'b0;
    endtask

    // Mostly well-formed blocks with random content, plus truncated blocks,
    // stray stream starts and junk after an end flag.
    task automatic gen_bytes(input int count, input bit start_first);
        int         target, mode, ndata, sel;
        logic [7:0] hdr, flag, data;
        bit         start_next;
        target = bytes_queued + count;
        start_next = start_first;
        while (bytes_queued < target) begin
            mode = $urandom_range(0, 9);
            if (mode < 2) hdr = {4'($urandom_range(2, 4)), 4'h0};
            else if (mode < 8) hdr = {4'($urandom_range(0, 4)), 4'($urandom_range(0, 15))};
            else hdr = 8'($urandom);
            push_byte(hdr, start_next);
            start_next = 1'b0;
            if (!cfg_format) begin
                sel = $urandom_range(0, 99);
                if (sel < 4) flag = cfg_end_code;
                else if (sel < 20) flag = cfg_loop_start_code;
                else if (sel < 36) flag = cfg_loop_end_code;
                else flag = 8'($urandom);
                push_byte(flag, 1'b0);
                if (flag == cfg_end_code) begin
                    repeat ($urandom_range(0, 3)) push_byte(8'($urandom), 1'b0);
                    start_next = 1'b1;
                    continue;
                end
            end
            ndata = ($urandom_range(0, 19) == 0) ? $urandom_range(0, 13) : DATA_BYTES;
            for (int i = 0; i < ndata; i++) begin
                if (mode == 0) data = 8'h88;
                else if (mode == 1) data = 8'h77;
                else data = 8'($urandom);
                push_byte(data, $urandom_range(0, 199) == 0);
            end
        end
    endtask

    initial begin
        reset_model();
        repeat (3) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Loop-start block driven into saturation by the strongest predictor.
        push_byte(8'h40, 1'b1);
        push_byte(LOOP_START_CODE_RESET, 1'b0);
        push_byte(8'h88, 1'b0);
        push_byte(8'h88, 1'b0);
        push_byte(8'h88, 1'b0);
        push_byte(8'h77, 1'b0);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        // Out-of-range predictor with the largest shift, in a loop-end block.
        push_byte(8'hFF, 1'b1);
        push_byte(LOOP_END_CODE_RESET, 1'b0);
        push_byte(8'h0F, 1'b0);
        push_byte(8'hF0, 1'b0);
        // End flag: the following byte is dropped until a new stream starts.
        push_byte(8'h0C, 1'b1);
        push_byte(END_CODE_RESET, 1'b0);
        push_byte(8'h12, 1'b0);
        push_byte(8'h34, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h81, 1'b0);
        // Stream start on a data position restarts with a header.
        push_byte(8'h23, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'h5A, 1'b0);
        gen_bytes(PHASE_BYTES, 1'b1);

        set_config(1'b0, 4'd1, 8'h00, 8'hFF, 8'h80);
        gen_bytes(PHASE_BYTES, 1'b1);
        @(posedge i_clk);
        sink_hold_left = SINK_HOLD;

        // End, loop start and loop end share one code.
        set_config(1'b0, 4'd1, 8'h55, 8'h55, 8'h55);
        gen_bytes(PHASE_BYTES, 1'b1);

        set_config(1'b0, 4'd1, 8'hFF, 8'h22, 8'h22);
        gen_bytes(PHASE_BYTES, 1'b1);

        set_config(1'b1, 4'd8, END_CODE_RESET, LOOP_START_CODE_RESET, LOOP_END_CODE_RESET);
        gen_bytes(PHASE_BYTES / 2, 1'b1);
        wait_drained();
        gen_bytes(PHASE_BYTES / 2, 1'b0);

        // Same stream continues, so the channel may already be past the new count.
        set_config(1'b1, 4'd3, END_CODE_RESET, LOOP_START_CODE_RESET, LOOP_END_CODE_RESET);
        gen_bytes(PHASE_BYTES, 1'b0);

        set_config(1'b1, 4'd0, END_CODE_RESET, LOOP_START_CODE_RESET, LOOP_END_CODE_RESET);
        gen_bytes(PHASE_BYTES, 1'b1);

        set_config(1'b1, 4'd15, END_CODE_RESET, LOOP_START_CODE_RESET, LOOP_END_CODE_RESET);
        gen_bytes(PHASE_BYTES, 1'b1);

        set_config(1'b1, 4'd1, END_CODE_RESET, LOOP_START_CODE_RESET, LOOP_END_CODE_RESET);
        no_idle = 1'b1;
        gen_bytes(PHASE_BYTES, 1'b1);
        wait_drained();
        no_idle = 1'b0;

        // Format switches while a block may be half done.
        set_config(1'b0, 4'($urandom_range(1, 8)), 8'($urandom), 8'($urandom), 8'($urandom));
        gen_bytes(PHASE_BYTES, 1'b0);

        set_config(1'b1, 4'($urandom_range(2, 7)), 8'($urandom), 8'($urandom), 8'($urandom));
        gen_bytes(PHASE_BYTES, 1'b0);

        set_config(1'b0, 4'd1, END_CODE_RESET, LOOP_START_CODE_RESET, LOOP_END_CODE_RESET);
        gen_bytes(PHASE_BYTES, 1'b1);

        wait_drained();
        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (pending_samples.size() != 0) begin
            report_mismatch($sformatf("%0d expected samples never arrived",
                                      pending_samples.size()));
        end
        if (error_count == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end

endmodule
